/* rtl/oad_pkg.sv */
// ----------------------------------------------------------------------------
// oad_pkg
// Shared codes, widths and types of the obstacle avoidance drive controller.
// ----------------------------------------------------------------------------
package oad_pkg;

	localparam int DistW  = 12;
	localparam int TimeW  = 16;
	localparam int TickW  = 32;
	localparam int ModeW  = 3;
	localparam int MotW   = 3;
	localparam int SpeedW = 10;

	// drive modes
	localparam logic [ModeW-1:0] MODE_FORWARD       = 3'd0;
	localparam logic [ModeW-1:0] MODE_CORRECT_LEFT  = 3'd1;
	localparam logic [ModeW-1:0] MODE_CORRECT_RIGHT = 3'd2;
	localparam logic [ModeW-1:0] MODE_TURN_LEFT     = 3'd3;
	localparam logic [ModeW-1:0] MODE_TURN_RIGHT    = 3'd4;
	localparam logic [ModeW-1:0] MODE_BACK          = 3'd5;
	localparam logic [ModeW-1:0] MODE_ESCAPE_LEFT   = 3'd6;
	localparam logic [ModeW-1:0] MODE_ESCAPE_RIGHT  = 3'd7;

	// motor commands
	localparam logic [MotW-1:0] MOT_NONE    = 3'd0;
	localparam logic [MotW-1:0] MOT_FORWARD = 3'd1;
	localparam logic [MotW-1:0] MOT_LEFT    = 3'd2;
	localparam logic [MotW-1:0] MOT_RIGHT   = 3'd3;
	localparam logic [MotW-1:0] MOT_BACK    = 3'd4;

	localparam logic [SpeedW-1:0] SPEED_STRAIGHT = 10'd730;
	localparam logic [SpeedW-1:0] SPEED_TURN     = 10'd870;

	// configuration register indexes
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_SAFE_DIST    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_EMER_DIST    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TURN_DIFF    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CORRECT_DIFF = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MIN_TURN     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TURN_TIME    = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_CORRECT_TIME = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_BACK_TIME    = 3'd7;

	// step queue between classifier and mode engine
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [DistW-1:0] obstacle_dist;
		logic [DistW-1:0] stop_dist;
		logic [DistW-1:0] turn_difference;
		logic [DistW-1:0] correct_difference;
		logic [DistW-1:0] side_gap_dist;
		logic [TimeW-1:0] turn_time_ms;
		logic [TimeW-1:0] correct_time_ms;
		logic [TimeW-1:0] back_time_ms;
	} cfg_t;

	// one classified step: everything that does not depend on the mode state
	typedef struct packed {
		logic             emer_left;
		logic             emer_right;
		logic             emer_front;
		logic             fwd_change;
		logic [ModeW-1:0] fwd_mode;
		logic [ModeW-1:0] esc_mode;
		logic [TickW-1:0] now_ms;
	} step_t;

endpackage

/* rtl/oad_front.sv */
// ----------------------------------------------------------------------------
// oad_front
// Accepts sensor beats and classifies them against the distance thresholds.
// ----------------------------------------------------------------------------
module oad_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  oad_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [oad_pkg::DistW-1:0]    left_dist,
	input  logic [oad_pkg::DistW-1:0]    front_dist,
	input  logic [oad_pkg::DistW-1:0]    right_dist,
	input  logic [oad_pkg::TickW-1:0]    now_ms,
	output logic                         step_valid,
	input  logic                         step_ready,
	output oad_pkg::step_t               step
);
	import oad_pkg::*;

	localparam int DiffW = DistW + 2;

	logic signed [DiffW-1:0] diff;
	logic signed [DiffW-1:0] tdiff;
	logic signed [DiffW-1:0] cdiff;
	logic                    left_pref;
	logic                    right_pref;
	step_t                   cls;
	logic                    valid_s1;
	step_t                   step_s1;

	assign diff  = signed'({2'b00, left_dist}) - signed'({2'b00, right_dist});
	assign tdiff = signed'({2'b00, cfg.turn_difference});
	assign cdiff = signed'({2'b00, cfg.correct_difference});

	assign left_pref  = (left_dist > cfg.side_gap_dist) && (left_dist > right_dist);
	assign right_pref = (right_dist > cfg.side_gap_dist) && (right_dist > left_dist);

	always_comb begin
		cls            = '0;
		cls.now_ms     = now_ms;
		cls.emer_left  = left_dist < cfg.stop_dist;
		cls.emer_right = right_dist < cfg.stop_dist;
		cls.emer_front = front_dist < cfg.stop_dist;
		cls.fwd_change = 1'b1;
		if (front_dist <= cfg.obstacle_dist) begin
			if (left_pref && diff > tdiff) begin
				cls.fwd_mode = MODE_TURN_LEFT;
			end else if (right_pref && diff < -tdiff) begin
				cls.fwd_mode = MODE_TURN_RIGHT;
			end else if (left_pref) begin
				cls.fwd_mode = MODE_TURN_LEFT;
			end else if (right_pref) begin
				cls.fwd_mode = MODE_TURN_RIGHT;
			end else begin
				cls.fwd_mode = MODE_BACK;
			end
		end else if (diff >= cdiff && diff < tdiff) begin
			cls.fwd_mode = MODE_CORRECT_LEFT;
		end else if (diff <= -cdiff && diff > -tdiff) begin
			cls.fwd_mode = MODE_CORRECT_RIGHT;
		end else begin
			cls.fwd_mode   = MODE_FORWARD;
			cls.fwd_change = 1'b0;
		end
		// way out once a reverse phase has run its time
		if (left_dist > right_dist && left_dist > cfg.side_gap_dist) begin
			cls.esc_mode = MODE_ESCAPE_LEFT;
		end else if (right_dist > left_dist && right_dist > cfg.side_gap_dist) begin
			cls.esc_mode = MODE_ESCAPE_RIGHT;
		end else begin
			cls.esc_mode = MODE_BACK;
		end
	end

	assign in_ready = !valid_s1 || step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			step_s1 <= cls;
		end
	end

	assign step_valid = valid_s1;
	assign step       = step_s1;

endmodule

/* rtl/oad_queue.sv */
// ----------------------------------------------------------------------------
// oad_queue
// Short queue of classified steps between the classifier and the mode engine.
// ----------------------------------------------------------------------------
module oad_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  oad_pkg::step_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output oad_pkg::step_t pop_data
);
	import oad_pkg::*;

	step_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != QCntW'(QDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/oad_back.sv */
// ----------------------------------------------------------------------------
// oad_back
// Mode engine: applies the emergency override and the timed mode rules,
// updates the drive mode and its start tick, registers the motor command.
// ----------------------------------------------------------------------------
module oad_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oad_pkg::cfg_t                 cfg,
	input  logic                          step_valid,
	output logic                          step_ready,
	input  oad_pkg::step_t                step,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [oad_pkg::MotW-1:0]      motion,
	output logic [oad_pkg::SpeedW-1:0]    drive_speed,
	output logic [oad_pkg::ModeW-1:0]     mode
);
	import oad_pkg::*;

	logic [ModeW-1:0]  mode_q;
	logic [TickW-1:0]  start_q;
	logic              out_valid_q;
	logic [MotW-1:0]   motion_q;
	logic [SpeedW-1:0] speed_q;
	logic [ModeW-1:0]  out_mode_q;

	logic [ModeW-1:0]  cur_mode;
	logic [TickW-1:0]  cur_start;
	logic [TickW-1:0]  elapsed;
	logic              corr_done;
	logic              turn_done;
	logic              back_done;
	logic [ModeW-1:0]  nxt_mode;
	logic [TickW-1:0]  nxt_start;
	logic [MotW-1:0]   nxt_motion;
	logic [SpeedW-1:0] nxt_speed;
	logic              take;

	// emergency override ahead of the mode rules
	always_comb begin
		cur_mode  = mode_q;
		cur_start = start_q;
		if (step.emer_left) begin
			if (mode_q != MODE_BACK && mode_q != MODE_ESCAPE_LEFT) begin
				cur_mode  = MODE_BACK;
				cur_start = step.now_ms;
			end
		end else if (step.emer_right) begin
			if (mode_q != MODE_BACK && mode_q != MODE_ESCAPE_RIGHT) begin
				cur_mode  = MODE_BACK;
				cur_start = step.now_ms;
			end
		end else if (step.emer_front) begin
			if (mode_q != MODE_BACK) begin
				cur_mode  = MODE_BACK;
				cur_start = step.now_ms;
			end
		end
	end

	assign elapsed   = step.now_ms - cur_start;
	assign corr_done = elapsed >= {{(TickW-TimeW){1'b0}}, cfg.correct_time_ms};
	assign turn_done = elapsed >= {{(TickW-TimeW){1'b0}}, cfg.turn_time_ms};
	assign back_done = elapsed >= {{(TickW-TimeW){1'b0}}, cfg.back_time_ms};

	always_comb begin
		nxt_mode   = cur_mode;
		nxt_start  = cur_start;
		nxt_motion = MOT_NONE;
		nxt_speed  = '0;
		case (cur_mode)
			MODE_FORWARD: begin
				if (step.fwd_change) begin
					nxt_mode  = step.fwd_mode;
					nxt_start = step.now_ms;
				end else begin
					nxt_motion = MOT_FORWARD;
					nxt_speed  = SPEED_STRAIGHT;
				end
			end
			MODE_CORRECT_LEFT, MODE_ESCAPE_LEFT: begin
				nxt_motion = MOT_LEFT;
				nxt_speed  = SPEED_TURN;
				if (corr_done) begin
					nxt_mode  = MODE_FORWARD;
					nxt_start = step.now_ms;
				end
			end
			MODE_CORRECT_RIGHT, MODE_ESCAPE_RIGHT: begin
				nxt_motion = MOT_RIGHT;
				nxt_speed  = SPEED_TURN;
				if (corr_done) begin
					nxt_mode  = MODE_FORWARD;
					nxt_start = step.now_ms;
				end
			end
			MODE_TURN_LEFT: begin
				nxt_motion = MOT_LEFT;
				nxt_speed  = SPEED_TURN;
				if (step.emer_left || step.emer_front) begin
					nxt_mode  = MODE_BACK;
					nxt_start = step.now_ms;
				end else if (turn_done) begin
					nxt_mode  = MODE_FORWARD;
					nxt_start = step.now_ms;
				end
			end
			MODE_TURN_RIGHT: begin
				nxt_motion = MOT_RIGHT;
				nxt_speed  = SPEED_TURN;
				if (step.emer_right || step.emer_front) begin
					nxt_mode  = MODE_BACK;
					nxt_start = step.now_ms;
				end else if (turn_done) begin
					nxt_mode  = MODE_FORWARD;
					nxt_start = step.now_ms;
				end
			end
			default: begin
				nxt_motion = MOT_BACK;
				nxt_speed  = SPEED_STRAIGHT;
				// restart the timer even when reverse is entered again
				if (back_done) begin
					nxt_mode  = step.esc_mode;
					nxt_start = step.now_ms;
				end
			end
		endcase
	end

	assign step_ready = !out_valid_q || out_ready;
	assign take       = step_valid && step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FORWARD;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_ready) begin
				out_valid_q <= step_valid;
			end
			if (take) begin
				mode_q  <= nxt_mode;
				start_q <= nxt_start;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			motion_q   <= nxt_motion;
			speed_q    <= nxt_speed;
			out_mode_q <= nxt_mode;
		end
	end

	assign out_valid   = out_valid_q;
	assign motion      = motion_q;
	assign drive_speed = speed_q;
	assign mode        = out_mode_q;

endmodule

/* rtl/obstacle_avoid_drive_fsm.sv */
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm
// Obstacle avoidance drive mode controller: one sensor beat in, one motor
// command beat out.
// ----------------------------------------------------------------------------
// Each sensor beat is one control step. A classifier stage compares the three
// distances against the thresholds, a four-entry queue holds classified
// steps, and the mode engine updates the drive mode and its start tick and
// registers the motor command. A new beat is taken every cycle while the
// classifier stage is empty or the queue has room. The rate is set by the
// mode engine, which must finish the mode and start tick update of one step
// before the next, and it does so as it takes each step. Either side may
// stall on its own; the queue absorbs the difference. Configuration writes
// are always accepted and must be made while no step is in flight.
module obstacle_avoid_drive_fsm (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// sensor beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // left_dist[11:0], front_dist[23:12],
	                              // right_dist[35:24], now_ms[67:36], zero[71:68]
	// motor command beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // motion[2:0], drive_speed[12:3], mode[15:13]
);
	import oad_pkg::*;

	cfg_t  cfg_q;
	logic  step_valid;
	logic  step_ready;
	step_t step;
	logic  q_valid;
	logic  q_ready;
	step_t q_step;

	logic [MotW-1:0]   motion;
	logic [SpeedW-1:0] drive_speed;
	logic [ModeW-1:0]  mode;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_dist      <= 12'd330;
			cfg_q.stop_dist          <= 12'd20;
			cfg_q.turn_difference    <= 12'd300;
			cfg_q.correct_difference <= 12'd200;
			cfg_q.side_gap_dist      <= 12'd150;
			cfg_q.turn_time_ms       <= 16'd700;
			cfg_q.correct_time_ms    <= 16'd150;
			cfg_q.back_time_ms       <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAFE_DIST:    cfg_q.obstacle_dist      <= cfg_data[DistW-1:0];
				REG_EMER_DIST:    cfg_q.stop_dist          <= cfg_data[DistW-1:0];
				REG_TURN_DIFF:    cfg_q.turn_difference    <= cfg_data[DistW-1:0];
				REG_CORRECT_DIFF: cfg_q.correct_difference <= cfg_data[DistW-1:0];
				REG_MIN_TURN:     cfg_q.side_gap_dist      <= cfg_data[DistW-1:0];
				REG_TURN_TIME:    cfg_q.turn_time_ms       <= cfg_data;
				REG_CORRECT_TIME: cfg_q.correct_time_ms    <= cfg_data;
				REG_BACK_TIME:    cfg_q.back_time_ms       <= cfg_data;
				default:          cfg_q                    <= cfg_q;
			endcase
		end
	end

	oad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.left_dist  (s_tdata[11:0]),
		.front_dist (s_tdata[23:12]),
		.right_dist (s_tdata[35:24]),
		.now_ms     (s_tdata[67:36]),
		.step_valid (step_valid),
		.step_ready (step_ready),
		.step       (step)
	);

	oad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (step_valid),
		.push_ready (step_ready),
		.push_data  (step),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_step)
	);

	oad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step_valid  (q_valid),
		.step_ready  (q_ready),
		.step        (q_step),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.motion      (motion),
		.drive_speed (drive_speed),
		.mode        (mode)
	);

	assign m_tdata = {mode, drive_speed, motion};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the obstacle avoidance drive mode controller.
// ----------------------------------------------------------------------------
// Sensor beats go in on the slave stream. A behavioral copy of the mode
// engine, with its own mode, start tick and register set, predicts the motor
// command beat for each accepted sensor beat. Command beats are checked field
// by field, in order. A short directed table comes first, then phases of
// random steps under several register settings and idle patterns.
module testbench;
	import oad_pkg::*;

	typedef struct packed {
		logic [MotW-1:0]   motion;
		logic [SpeedW-1:0] speed;
		logic [ModeW-1:0]  mode;
	} cmd_t;

	typedef struct {
		logic [DistW-1:0] left_d;
		logic [DistW-1:0] front_d;
		logic [DistW-1:0] right_d;
		logic [TickW-1:0] now;
		bit               known;
		cmd_t             want;
	} probe_row_t;

	localparam int NProbe = 25;
	localparam int PhaseItems = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// predictor state
	cfg_t             ctl;
	logic [ModeW-1:0] pred_mode;
	logic [TickW-1:0] pred_start;
	cmd_t             pending_cmds[$];

	probe_row_t probe_rows [NProbe];
	int n_errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	obstacle_avoid_drive_fsm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic cfg_t default_cfg();
		cfg_t c;
		c.obstacle_dist      = 12'd330;
		c.stop_dist          = 12'd20;
		c.turn_difference    = 12'd300;
		c.correct_difference = 12'd200;
		c.side_gap_dist      = 12'd150;
		c.turn_time_ms       = 16'd700;
		c.correct_time_ms    = 16'd150;
		c.back_time_ms       = 16'd100;
		return c;
	endfunction

	function automatic cfg_t random_cfg(bit wide);
		cfg_t c;
		c.obstacle_dist      = DistW'(wide ? $urandom_range(0, 4095) : $urandom_range(100, 1500));
		c.stop_dist          = DistW'(wide ? $urandom_range(0, 4095) : $urandom_range(0, 120));
		c.turn_difference    = DistW'(wide ? $urandom_range(0, 4095) : $urandom_range(0, 800));
		c.correct_difference = DistW'(wide ? $urandom_range(0, 4095) : $urandom_range(0, 600));
		c.side_gap_dist      = DistW'(wide ? $urandom_range(0, 4095) : $urandom_range(0, 600));
		c.turn_time_ms       = TimeW'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 1000));
		c.correct_time_ms    = TimeW'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 1000));
		c.back_time_ms       = TimeW'(wide ? $urandom_range(0, 65535) : $urandom_range(0, 1000));
		return c;
	endfunction

	function automatic void set_drive_mode(logic [ModeW-1:0] m, logic [TickW-1:0] now);
		pred_mode  = m;
		pred_start = now;
	endfunction

	// one control step of the mode engine; updates the predicted mode state
	function automatic cmd_t advance_drive(logic [DistW-1:0] l, logic [DistW-1:0] f,
			logic [DistW-1:0] r, logic [TickW-1:0] now);
		cmd_t c;
		int diff;
		int td;
		int cd;
		logic [TickW-1:0] el;
		diff = int'(l) - int'(r);
		td = int'(ctl.turn_difference);
		cd = int'(ctl.correct_difference);
		c.motion = MOT_NONE;
		c.speed  = '0;

		// emergency override: escape toward the blocked side does not restart
		if (l < ctl.stop_dist) begin
			if (pred_mode != MODE_BACK && pred_mode != MODE_ESCAPE_LEFT)
				set_drive_mode(MODE_BACK, now);
		end else if (r < ctl.stop_dist) begin
			if (pred_mode != MODE_BACK && pred_mode != MODE_ESCAPE_RIGHT)
				set_drive_mode(MODE_BACK, now);
		end else if (f < ctl.stop_dist) begin
			if (pred_mode != MODE_BACK)
				set_drive_mode(MODE_BACK, now);
		end

		el = now - pred_start;

		case (pred_mode)
			MODE_FORWARD: begin
				if (f <= ctl.obstacle_dist) begin
					if (l > ctl.side_gap_dist && l > r && diff > td)
						set_drive_mode(MODE_TURN_LEFT, now);
					else if (r > ctl.side_gap_dist && r > l && diff < -td)
						set_drive_mode(MODE_TURN_RIGHT, now);
					else if (l > ctl.side_gap_dist && l > r)
						set_drive_mode(MODE_TURN_LEFT, now);
					else if (r > ctl.side_gap_dist && r > l)
						set_drive_mode(MODE_TURN_RIGHT, now);
					else
						set_drive_mode(MODE_BACK, now);
				end else if (diff >= cd && diff < td) begin
					set_drive_mode(MODE_CORRECT_LEFT, now);
				end else if (diff <= -cd && diff > -td) begin
					set_drive_mode(MODE_CORRECT_RIGHT, now);
				end else begin
					c.motion = MOT_FORWARD;
					c.speed  = SPEED_STRAIGHT;
				end
			end
			MODE_CORRECT_LEFT, MODE_ESCAPE_LEFT: begin
				c.motion = MOT_LEFT;
				c.speed  = SPEED_TURN;
				if (el >= ctl.correct_time_ms)
					set_drive_mode(MODE_FORWARD, now);
			end
			MODE_CORRECT_RIGHT, MODE_ESCAPE_RIGHT: begin
				c.motion = MOT_RIGHT;
				c.speed  = SPEED_TURN;
				if (el >= ctl.correct_time_ms)
					set_drive_mode(MODE_FORWARD, now);
			end
			MODE_TURN_LEFT: begin
				c.motion = MOT_LEFT;
				c.speed  = SPEED_TURN;
				if (l < ctl.stop_dist || f < ctl.stop_dist)
					set_drive_mode(MODE_BACK, now);
				else if (el >= ctl.turn_time_ms)
					set_drive_mode(MODE_FORWARD, now);
			end
			MODE_TURN_RIGHT: begin
				c.motion = MOT_RIGHT;
				c.speed  = SPEED_TURN;
				if (r < ctl.stop_dist || f < ctl.stop_dist)
					set_drive_mode(MODE_BACK, now);
				else if (el >= ctl.turn_time_ms)
					set_drive_mode(MODE_FORWARD, now);
			end
			default: begin
				c.motion = MOT_BACK;
				c.speed  = SPEED_STRAIGHT;
				if (el >= ctl.back_time_ms) begin
					if (l > r && l > ctl.side_gap_dist)
						set_drive_mode(MODE_ESCAPE_LEFT, now);
					else if (r > l && r > ctl.side_gap_dist)
						set_drive_mode(MODE_ESCAPE_RIGHT, now);
					else
						set_drive_mode(MODE_BACK, now);
				end
			end
		endcase

		c.mode = pred_mode;
		return c;
	endfunction

	function automatic logic [DistW-1:0] clip_dist(int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return DistW'(v);
	endfunction

	function automatic int near_value(int base);
		int j;
		j = int'($urandom_range(0, 6));
		return base + j - 3;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("t=%0t  mismatch: %s", $time, what);
		n_errors++;
	endtask

	// mostly plausible sensor steps around the thresholds, some pure noise
	task automatic next_sensor(output logic [DistW-1:0] l, output logic [DistW-1:0] f,
			output logic [DistW-1:0] r, inout logic [TickW-1:0] now);
		int dt;
		int lv;
		int off;
		if ($urandom_range(0, 99) < 8) begin
			l   = DistW'($urandom);
			f   = DistW'($urandom);
			r   = DistW'($urandom);
			now = $urandom;
		end else begin
			case ($urandom_range(0, 5))
				0: dt = int'($urandom_range(0, 3));
				1: dt = near_value(int'(ctl.turn_time_ms));
				2: dt = near_value(int'(ctl.correct_time_ms));
				3: dt = near_value(int'(ctl.back_time_ms));
				default: dt = int'($urandom_range(0, 400));
			endcase
			now = now + TickW'(dt);

			case ($urandom_range(0, 9))
				5, 6, 7: f = clip_dist(near_value(int'(ctl.obstacle_dist)));
				8: f = clip_dist(near_value(int'(ctl.stop_dist)));
				9: f = DistW'($urandom_range(0, 4095));
				default: f = clip_dist(int'(ctl.obstacle_dist) + 1 + int'($urandom_range(0, 3000)));
			endcase

			case ($urandom_range(0, 7))
				0: lv = near_value(int'(ctl.side_gap_dist));
				1: lv = near_value(int'(ctl.stop_dist));
				2: lv = $urandom_range(0, 1) ? 4095 : 0;
				default: lv = int'($urandom_range(0, 4095));
			endcase
			case ($urandom_range(0, 5))
				0, 1: off = near_value(int'(ctl.turn_difference));
				2, 3: off = near_value(int'(ctl.correct_difference));
				4: off = int'($urandom_range(0, 4095));
				default: off = 0;
			endcase
			l = clip_dist(lv);
			r = $urandom_range(0, 1) ? clip_dist(lv + off) : clip_dist(lv - off);
		end
	endtask

	task automatic send_sensor(input logic [DistW-1:0] l, input logic [DistW-1:0] f,
			input logic [DistW-1:0] r, input logic [TickW-1:0] now,
			input bit known, input cmd_t want);
		cmd_t c;
		logic fire;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, now, r, f, l};
		do begin
			@(negedge clk);
			fire = s_tready;
			if (fire) begin
				c = advance_drive(l, f, r, now);
				pending_cmds.push_back(known ? want : c);
			end
			@(posedge clk);
		end while (!fire);
	endtask

	// write all eight registers; upper bits of the 12-bit ones carry junk
	task automatic load_settings(input cfg_t c);
		logic [15:0] vals [8];
		logic fire;
		vals[REG_SAFE_DIST]    = {4'($urandom), c.obstacle_dist};
		vals[REG_EMER_DIST]    = {4'($urandom), c.stop_dist};
		vals[REG_TURN_DIFF]    = {4'($urandom), c.turn_difference};
		vals[REG_CORRECT_DIFF] = {4'($urandom), c.correct_difference};
		vals[REG_MIN_TURN]     = {4'($urandom), c.side_gap_dist};
		vals[REG_TURN_TIME]    = c.turn_time_ms;
		vals[REG_CORRECT_TIME] = c.correct_time_ms;
		vals[REG_BACK_TIME]    = c.back_time_ms;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			do begin
				@(negedge clk);
				fire = cfg_ready;
				@(posedge clk);
			end while (!fire);
		end
		cfg_valid <= 1'b0;
		ctl = c;
	endtask

	// wait for every expected command, then cover the pipeline depth
	task automatic settle();
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// receiver: random stalls, plus an occasional long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// outputs are stable at the falling edge and hold through the next rising edge
	always @(negedge clk) begin : check_cmd
		cmd_t got;
		cmd_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			got.motion = m_tdata[2:0];
			got.speed  = m_tdata[12:3];
			got.mode   = m_tdata[15:13];
			if (pending_cmds.size() == 0) begin
				flag_mismatch($sformatf("command beat %h with nothing expected", m_tdata));
			end else begin
				exp_c = pending_cmds.pop_front();
				if (got.motion !== exp_c.motion)
					flag_mismatch($sformatf("motion %0d, want %0d", got.motion, exp_c.motion));
				if (got.speed !== exp_c.speed)
					flag_mismatch($sformatf("speed %0d, want %0d", got.speed, exp_c.speed));
				if (got.mode !== exp_c.mode)
					flag_mismatch($sformatf("mode %0d, want %0d", got.mode, exp_c.mode));
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		logic [DistW-1:0] l;
		logic [DistW-1:0] f;
		logic [DistW-1:0] r;
		logic [TickW-1:0] now;
		ctl        = default_cfg();
		pred_mode  = MODE_FORWARD;
		pred_start = '0;

		// walks the modes from reset under the reset register values
		probe_rows = '{
			'{12'd4095, 12'd4095, 12'd4095, 32'd0,    1'b1, {MOT_FORWARD, SPEED_STRAIGHT, MODE_FORWARD}},
			'{12'd0,    12'd4095, 12'd4095, 32'd10,   1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd4095, 12'd4095, 12'd0,    32'd50,   1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd100,  12'd4095, 12'd100,  32'd110,  1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd4095, 12'd4095, 12'd1000, 32'd210,  1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_ESCAPE_LEFT}},
			'{12'd10,   12'd4095, 12'd4095, 32'd250,  1'b1, {MOT_LEFT, SPEED_TURN, MODE_ESCAPE_LEFT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd360,  1'b1, {MOT_LEFT, SPEED_TURN, MODE_FORWARD}},
			'{12'd4000, 12'd330,  12'd100,  32'd400,  1'b1, {MOT_NONE, 10'd0, MODE_TURN_LEFT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1100, 1'b1, {MOT_LEFT, SPEED_TURN, MODE_FORWARD}},
			'{12'd1200, 12'd4095, 12'd1000, 32'd1200, 1'b1, {MOT_NONE, 10'd0, MODE_CORRECT_LEFT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1350, 1'b1, {MOT_LEFT, SPEED_TURN, MODE_FORWARD}},
			'{12'd1000, 12'd4095, 12'd1200, 32'd1400, 1'b1, {MOT_NONE, 10'd0, MODE_CORRECT_RIGHT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1549, 1'b1, {MOT_RIGHT, SPEED_TURN, MODE_CORRECT_RIGHT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1550, 1'b1, {MOT_RIGHT, SPEED_TURN, MODE_FORWARD}},
			'{12'd4095, 12'd0,    12'd4095, 32'd1600, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd100,  12'd4095, 12'd4095, 32'd1700, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_ESCAPE_RIGHT}},
			'{12'd4095, 12'd4095, 12'd0,    32'd1720, 1'b1, {MOT_RIGHT, SPEED_TURN, MODE_ESCAPE_RIGHT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1850, 1'b1, {MOT_RIGHT, SPEED_TURN, MODE_FORWARD}},
			'{12'd100,  12'd100,  12'd4000, 32'd1900, 1'b1, {MOT_NONE, 10'd0, MODE_TURN_RIGHT}},
			'{12'd4095, 12'd4095, 12'd4095, 32'd1950, 1'b1, {MOT_RIGHT, SPEED_TURN, MODE_TURN_RIGHT}},
			// tick wraps while in back mode
			'{12'd4095, 12'd0,    12'd4095, 32'hFFFF_FFF0, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd4095, 12'd4095, 12'd4095, 32'h0000_0050, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd100,  12'd4095, 12'd100,  32'h0000_0054, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_BACK}},
			'{12'd4095, 12'd4095, 12'd4094, 32'h0000_0200, 1'b1, {MOT_BACK, SPEED_STRAIGHT, MODE_ESCAPE_LEFT}},
			'{12'd0,    12'd0,    12'd0,    32'h0000_0300, 1'b0, '0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i])
			send_sensor(probe_rows[i].left_d, probe_rows[i].front_d, probe_rows[i].right_d,
				probe_rows[i].now, probe_rows[i].known, probe_rows[i].want);
		s_tvalid <= 1'b0;
		now = 32'h0000_0300;

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: load_settings(default_cfg());
				1: load_settings('0);
				2: load_settings('1);
				default: load_settings(random_cfg(ph[0]));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			// long hold-off while the sender keeps offering: fill the queue
			if (ph == 4 || ph == 7)
				hold_left = 150;
			for (int n = 0; n < PhaseItems; n++) begin
				next_sensor(l, f, r, now);
				send_sensor(l, f, r, now, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		settle();
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
